### rtl/z85rc_pkg.sv
package z85rc_pkg;

    localparam int unsigned RADIX = 85;
    localparam int unsigned GROUP = 5;

    // floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
    localparam int unsigned RECIP_SHIFT = 38;

    localparam logic [2:0] GROUP_END_POS = 3'(GROUP - 1);

    typedef logic [6:0]  digit_t;
    typedef logic [7:0]  char_t;
    typedef logic [31:0] word_t;
    typedef logic [25:0] weight_t;

    typedef enum logic
    {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    typedef enum logic
    {
        REG_DIRECTION     = 1'b0,
        REG_ROTATION_STEP = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic   known;
        digit_t idx;
    } char_lookup_t;

    // both operands below 85
    function automatic digit_t add_mod85(digit_t a, digit_t b);
        logic [7:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 8'(RADIX))
        begin
            s = s - 8'(RADIX);
        end
        return s[6:0];
    endfunction

    function automatic weight_t digit_weight(logic [2:0] pos);
        weight_t w;
        case (pos)
            3'd0:    w = 26'd52200625;
            3'd1:    w = 26'd614125;
            3'd2:    w = 26'd7225;
            3'd3:    w = 26'd85;
            default: w = 26'd1;
        endcase
        return w;
    endfunction

    function automatic char_t digit_to_char(digit_t d);
        char_t c;
        if (d < 7'd10)
        begin
            c = 8'h30 + {1'b0, d};
        end
        else if (d < 7'd36)
        begin
            c = 8'h61 + {1'b0, d} - 8'd10;
        end
        else if (d < 7'd62)
        begin
            c = 8'h41 + {1'b0, d} - 8'd36;
        end
        else
        begin
            case (d)
                7'd62:   c = 8'h2E;
                7'd63:   c = 8'h2D;
                7'd64:   c = 8'h3A;
                7'd65:   c = 8'h2B;
                7'd66:   c = 8'h3D;
                7'd67:   c = 8'h5E;
                7'd68:   c = 8'h21;
                7'd69:   c = 8'h2F;
                7'd70:   c = 8'h2A;
                7'd71:   c = 8'h3F;
                7'd72:   c = 8'h26;
                7'd73:   c = 8'h3C;
                7'd74:   c = 8'h3E;
                7'd75:   c = 8'h28;
                7'd76:   c = 8'h29;
                7'd77:   c = 8'h5B;
                7'd78:   c = 8'h5D;
                7'd79:   c = 8'h7B;
                7'd80:   c = 8'h7D;
                7'd81:   c = 8'h40;
                7'd82:   c = 8'h25;
                7'd83:   c = 8'h24;
                7'd84:   c = 8'h23;
                default: c = 8'h30;
            endcase
        end
        return c;
    endfunction

    function automatic char_lookup_t char_to_digit(char_t c);
        char_lookup_t r;
        r.known = 1'b1;
        r.idx   = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.idx = 7'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.idx = 7'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.idx = 7'(c - 8'h41 + 8'd36);
        end
        else
        begin
            case (c)
                8'h2E:   r.idx = 7'd62;
                8'h2D:   r.idx = 7'd63;
                8'h3A:   r.idx = 7'd64;
                8'h2B:   r.idx = 7'd65;
                8'h3D:   r.idx = 7'd66;
                8'h5E:   r.idx = 7'd67;
                8'h21:   r.idx = 7'd68;
                8'h2F:   r.idx = 7'd69;
                8'h2A:   r.idx = 7'd70;
                8'h3F:   r.idx = 7'd71;
                8'h26:   r.idx = 7'd72;
                8'h3C:   r.idx = 7'd73;
                8'h3E:   r.idx = 7'd74;
                8'h28:   r.idx = 7'd75;
                8'h29:   r.idx = 7'd76;
                8'h5B:   r.idx = 7'd77;
                8'h5D:   r.idx = 7'd78;
                8'h7B:   r.idx = 7'd79;
                8'h7D:   r.idx = 7'd80;
                8'h40:   r.idx = 7'd81;
                8'h25:   r.idx = 7'd82;
                8'h24:   r.idx = 7'd83;
                8'h23:   r.idx = 7'd84;
                default: r.known = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/z85_rotating_codec.sv
// encode: a word passes the input register, divide-by-85 unit and character emitter, which sends
//   one character per cycle while the output is free and paces the words (divider runs alongside)
// decode: one character per cycle unless a fifth character waits for the output register
// rst_n clears direction, step, rotation offset, digit count, accumulator and all valid flags
module z85_rotating_codec
    import z85rc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], char_in[39:32]
    input  logic        s_tuser,   // start_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // char_out[7:0], word_out[39:8]
    output logic        m_tlast,
    output logic        m_tuser,   // bad_char
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wdata
);

    dir_t        dir_reg, dir_next;
    digit_t      step_reg, step_next;

    logic        in_vld_reg, in_vld_next;
    word_t       in_word_reg, in_word_next;
    digit_t      in_idx_reg, in_idx_next;
    logic        in_known_reg, in_known_next;
    logic        in_sos_reg, in_sos_next;

    logic        div_busy_reg, div_busy_next;
    logic [2:0]  div_cnt_reg, div_cnt_next;
    word_t       quo_reg, quo_next;
    digit_t      rem_reg [GROUP-1], rem_next [GROUP-1];
    logic        div_sos_reg, div_sos_next;

    logic        emit_busy_reg, emit_busy_next;
    logic [2:0]  emit_pos_reg, emit_pos_next;
    digit_t      emit_dig_reg [GROUP], emit_dig_next [GROUP];
    logic        emit_sos_reg, emit_sos_next;

    logic        out_vld_reg, out_vld_next;
    char_t       out_char_reg, out_char_next;
    word_t       out_word_reg, out_word_next;
    logic        out_last_reg, out_last_next;
    logic        out_bad_reg, out_bad_next;

    digit_t      off_reg, off_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    word_t       acc_reg, acc_next;
    logic        bad_reg, bad_next;

    digit_t       step_mod;
    logic         out_load_ok;
    logic         div_done;
    logic         emit_fire, emit_final, emit_take;
    logic         handoff, div_take;
    logic         enc_take, dec_fire, in_take;
    logic [63:0]  div_prod;
    logic [25:0]  div_q;
    word_t        div_q85;
    word_t        div_rem;
    logic         emit_first_clear;
    digit_t       enc_off, neg_off;
    char_t        enc_char;
    digit_t       dec_off, dec_digit;
    logic [2:0]   dec_cnt, dec_pos;
    word_t        dec_acc, dec_sum;
    logic         dec_bad, dec_bad_new, dec_group_end;
    logic [32:0]  dec_prod;
    char_lookup_t lookup;

    assign step_mod    = (step_reg >= 7'(RADIX)) ? step_reg - 7'(RADIX) : step_reg;
    assign out_load_ok = !out_vld_reg || m_tready;
    assign div_done    = div_cnt_reg == GROUP_END_POS;

    assign emit_fire  = emit_busy_reg && out_load_ok;
    assign emit_final = emit_pos_reg == GROUP_END_POS;
    assign emit_take  = !emit_busy_reg || (emit_fire && emit_final);
    assign handoff    = div_busy_reg && div_done && emit_take;
    assign div_take   = !div_busy_reg || handoff;

    // only the fifth character of a group needs the result register
    assign enc_take = in_vld_reg && (dir_reg == DIR_ENCODE) && div_take;
    assign dec_fire = in_vld_reg && (dir_reg == DIR_DECODE) && (out_load_ok || !dec_group_end);
    assign in_take  = enc_take || dec_fire;
    assign s_tready = !in_vld_reg || in_take;

    assign lookup = char_to_digit(s_tdata[39:32]);

    // divide by 85, least significant digit first
    assign div_prod = {32'd0, quo_reg} * {32'd0, RECIP_85};
    assign div_q    = div_prod[63:RECIP_SHIFT];
    assign div_q85  = {6'd0, div_q} * 32'(RADIX);
    assign div_rem  = quo_reg - div_q85;

    // character emitter
    assign emit_first_clear = emit_sos_reg && (emit_pos_reg == 3'd0);
    assign enc_off  = emit_first_clear ? 7'd0 : off_reg;
    assign neg_off  = (enc_off == 7'd0) ? 7'd0 : 7'(RADIX) - enc_off;
    assign enc_char = digit_to_char(add_mod85(emit_dig_reg[0], neg_off));

    // decode step
    assign dec_off       = in_sos_reg ? 7'd0 : off_reg;
    assign dec_cnt       = in_sos_reg ? 3'd0 : dcnt_reg;
    assign dec_acc       = in_sos_reg ? 32'd0 : acc_reg;
    assign dec_bad       = in_sos_reg ? 1'b0 : bad_reg;
    assign dec_pos       = (dec_cnt > GROUP_END_POS) ? GROUP_END_POS : dec_cnt;
    assign dec_digit     = add_mod85(in_idx_reg, dec_off);
    assign dec_prod      = {26'd0, dec_digit} * {7'd0, digit_weight(dec_pos)};
    assign dec_sum       = dec_acc + dec_prod[31:0];
    assign dec_bad_new   = dec_bad || !in_known_reg;
    assign dec_group_end = dec_pos == GROUP_END_POS;

    always_comb
    begin
        dir_next      = dir_reg;
        step_next     = step_reg;
        in_vld_next   = in_vld_reg;
        in_word_next  = in_word_reg;
        in_idx_next   = in_idx_reg;
        in_known_next = in_known_reg;
        in_sos_next   = in_sos_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_sos_next  = div_sos_reg;
        emit_busy_next = emit_busy_reg;
        emit_pos_next  = emit_pos_reg;
        emit_dig_next  = emit_dig_reg;
        emit_sos_next  = emit_sos_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_char_next = out_char_reg;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        out_bad_next  = out_bad_reg;
        off_next      = off_reg;
        dcnt_next     = dcnt_reg;
        acc_next      = acc_reg;
        bad_next      = bad_reg;

        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_DIRECTION:     dir_next  = dir_t'(cfg_wdata[0]);
                REG_ROTATION_STEP: step_next = cfg_wdata;
            endcase
        end

        if (s_tready)
        begin
            in_vld_next = s_tvalid;
        end
        if (s_tvalid && s_tready)
        begin
            in_word_next  = s_tdata[31:0];
            in_idx_next   = lookup.idx;
            in_known_next = lookup.known;
            in_sos_next   = s_tuser;
        end

        if (div_take)
        begin
            div_busy_next = enc_take;
            if (enc_take)
            begin
                div_cnt_next = 3'd0;
                quo_next     = in_word_reg;
                div_sos_next = in_sos_reg;
            end
        end
        else if (div_busy_reg && !div_done)
        begin
            quo_next    = {6'd0, div_q};
            rem_next[0] = div_rem[6:0];
            for (int i = 1; i < GROUP - 1; i++)
            begin
                rem_next[i] = rem_reg[i-1];
            end
            div_cnt_next = div_cnt_reg + 3'd1;
        end

        if (emit_take)
        begin
            emit_busy_next = handoff;
            if (handoff)
            begin
                emit_pos_next    = 3'd0;
                emit_sos_next    = div_sos_reg;
                emit_dig_next[0] = quo_reg[6:0];
                for (int i = 1; i < GROUP; i++)
                begin
                    emit_dig_next[i] = rem_reg[i-1];
                end
            end
        end
        else if (emit_fire)
        begin
            emit_pos_next = emit_pos_reg + 3'd1;
            for (int i = 0; i < GROUP - 1; i++)
            begin
                emit_dig_next[i] = emit_dig_reg[i+1];
            end
        end

        if (emit_fire)
        begin
            off_next      = add_mod85(enc_off, step_mod);
            out_vld_next  = 1'b1;
            out_char_next = enc_char;
            out_word_next = '0;
            out_last_next = emit_final;
            out_bad_next  = 1'b0;
            if (emit_first_clear)
            begin
                dcnt_next = 3'd0;
                acc_next  = '0;
                bad_next  = 1'b0;
            end
        end

        if (dec_fire)
        begin
            off_next = add_mod85(dec_off, step_mod);
            if (dec_group_end)
            begin
                out_vld_next  = 1'b1;
                out_char_next = '0;
                out_word_next = dec_sum;
                out_last_next = 1'b1;
                out_bad_next  = dec_bad_new;
                dcnt_next     = 3'd0;
                acc_next      = '0;
                bad_next      = 1'b0;
            end
            else
            begin
                dcnt_next = dec_pos + 3'd1;
                acc_next  = dec_sum;
                bad_next  = dec_bad_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_ENCODE;
            step_reg      <= '0;
            in_vld_reg    <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            emit_busy_reg <= 1'b0;
            emit_pos_reg  <= '0;
            out_vld_reg   <= 1'b0;
            off_reg       <= '0;
            dcnt_reg      <= '0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            step_reg      <= step_next;
            in_vld_reg    <= in_vld_next;
            div_busy_reg  <= div_busy_next;
            div_cnt_reg   <= div_cnt_next;
            emit_busy_reg <= emit_busy_next;
            emit_pos_reg  <= emit_pos_next;
            out_vld_reg   <= out_vld_next;
            off_reg       <= off_next;
            dcnt_reg      <= dcnt_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg   <= in_word_next;
        in_idx_reg    <= in_idx_next;
        in_known_reg  <= in_known_next;
        in_sos_reg    <= in_sos_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_sos_reg   <= div_sos_next;
        emit_dig_reg  <= emit_dig_next;
        emit_sos_reg  <= emit_sos_next;
        out_char_reg  <= out_char_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_word_reg, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

    // rotation offset stays a valid digit
    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg < 7'(RADIX))
        else $error("rotation offset out of range");

    // decode group count never passes the group length
    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= GROUP_END_POS)
        else $error("decode digit count out of range");

    // after four divisions the quotient is the leading digit
    a_div_lead: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg && div_done |-> quo_reg < 32'(RADIX))
        else $error("leading digit out of range");

    // a held input item is never overwritten
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !in_take |-> !s_tready)
        else $error("input register overwritten");

    // a finished encode word moves to the emitter only when it frees up
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        handoff |=> emit_busy_reg && emit_pos_reg == 3'd0)
        else $error("emitter handoff lost");

endmodule

### tb/sv/testbench.sv
module testbench
    import z85rc_pkg::*;
();

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 23;

    typedef struct
    {
        word_t word;
        char_t ch;
        logic  sos;
    } codec_item_t;

    typedef struct
    {
        char_t ch;
        word_t word;
        logic  last;
        logic  bad;
    } codec_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // data_word[31:0], char_in[39:32]
    logic        s_tuser   = 1'b0; // start_of_stream
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // char_out[7:0], word_out[39:8]
    logic        m_tlast;
    logic        m_tuser;          // bad_char
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    string z85_chars =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
    int unsigned pow85 [5] = '{52200625, 614125, 7225, 85, 1};

    // codec state as the block should hold it
    dir_t        cur_dir    = DIR_ENCODE;
    logic [6:0]  cur_step   = '0;
    digit_t      rot_offset = '0;
    int unsigned group_pos  = 0;
    word_t       group_acc  = '0;
    logic        group_bad  = 1'b0;

    codec_item_t   item_q [$];
    codec_item_t   offer_item;
    codec_result_t result_q [$];
    logic          in_taken = 1'b0;

    int items_queued    = 0;
    int items_taken     = 0;
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    int errors          = 0;
    int results_checked = 0;
    int words_encoded   = 0;
    int groups_decoded  = 0;
    int bad_groups      = 0;

    z85_rotating_codec u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [39:0] want, logic [39:0] got);
        errors++;
        $display("tb: mismatch, %s: expected %0h, got %0h at %0t", what, want, got, $time);
    endtask

    function automatic digit_t next_offset(digit_t off, logic [6:0] step);
        return digit_t'((int'(off) + int'(step) % RADIX) % RADIX);
    endfunction

    task automatic encode_word(word_t w);
        int unsigned   rest;
        int unsigned   d;
        int unsigned   pos;
        codec_result_t r;
        rest = w;
        for (int k = 0; k < GROUP; k++)
        begin
            d      = rest / pow85[k];
            rest   = rest - d * pow85[k];
            pos    = (d + RADIX - rot_offset) % RADIX;
            r.ch   = char_t'(z85_chars[pos]);
            r.word = '0;
            r.last = (k == GROUP - 1);
            r.bad  = 1'b0;
            result_q.insert(result_q.size(), r);
            rot_offset = next_offset(rot_offset, cur_step);
        end
        words_encoded++;
    endtask

    task automatic decode_char(char_t c);
        int unsigned   idx;
        bit            found;
        codec_result_t r;
        idx   = 0;
        found = 1'b0;
        for (int i = 0; i < RADIX; i++)
        begin
            if (!found && char_t'(z85_chars[i]) == c)
            begin
                idx   = i;
                found = 1'b1;
            end
        end
        // unknown bytes count as digit index zero but taint the group
        if (!found)
        begin
            group_bad = 1'b1;
        end
        group_acc  = group_acc + word_t'(((idx + rot_offset) % RADIX) * pow85[group_pos]);
        rot_offset = next_offset(rot_offset, cur_step);
        group_pos++;
        if (group_pos == GROUP)
        begin
            r.ch   = '0;
            r.word = group_acc;
            r.last = 1'b1;
            r.bad  = group_bad;
            result_q.insert(result_q.size(), r);
            groups_decoded++;
            if (group_bad)
            begin
                bad_groups++;
            end
            group_pos = 0;
            group_acc = '0;
            group_bad = 1'b0;
        end
    endtask

    task automatic advance_codec(codec_item_t it);
        if (it.sos)
        begin
            rot_offset = '0;
            group_pos  = 0;
            group_acc  = '0;
            group_bad  = 1'b0;
        end
        if (cur_dir == DIR_ENCODE)
        begin
            encode_word(it.word);
        end
        else
        begin
            decode_char(it.ch);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        logic keep;
        keep     = s_tvalid && !in_taken;
        in_taken = 1'b0;
        if (!keep && item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            offer_item = item_q.pop_front();
            keep       = 1'b1;
            s_tdata   <= {offer_item.ch, offer_item.word};
            s_tuser   <= offer_item.sos;
        end
        s_tvalid <= keep;
    end

    // receiver, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // checker, predictor and watchdog
    always @(posedge clk)
    begin
        codec_result_t want;
        bit            busy;
        if (rst_n)
        begin
            busy = cfg_we;
            if (m_tvalid && m_tready)
            begin
                busy = 1'b1;
                if (result_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", '0, m_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    results_checked++;
                    if (m_tdata[7:0] !== want.ch)
                    begin
                        report_mismatch("char_out", 40'(want.ch), 40'(m_tdata[7:0]));
                    end
                    if (m_tdata[39:8] !== want.word)
                    begin
                        report_mismatch("word_out", 40'(want.word), 40'(m_tdata[39:8]));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch("last", 40'(want.last), 40'(m_tlast));
                    end
                    if (m_tuser !== want.bad)
                    begin
                        report_mismatch("bad_char", 40'(want.bad), 40'(m_tuser));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                busy     = 1'b1;
                in_taken = 1'b1;
                items_taken++;
                advance_codec(offer_item);
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_item(word_t w, char_t c, logic sos);
        codec_item_t it;
        it.word = w;
        it.ch   = c;
        it.sos  = sos;
        item_q.insert(item_q.size(), it);
        items_queued++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [6:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_DIRECTION)
        begin
            cur_dir = dir_t'(val[0]);
        end
        else
        begin
            cur_step = val;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        while (items_taken != items_queued || result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(dir_t d, logic [6:0] step, int idle_pct, int stall, bit hold);
        word_t w;
        char_t c;
        logic  sos;
        write_reg(REG_DIRECTION, 7'(d));
        write_reg(REG_ROTATION_STEP, step);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            w   = $urandom;
            c   = char_t'($urandom_range(255));
            sos = ($urandom_range(99) < 5);
            if (d == DIR_ENCODE)
            begin
                case ($urandom_range(9))
                    0:       w = '0;
                    1:       w = '1;
                    default: ;
                endcase
            end
            else if ($urandom_range(99) >= 8)
            begin
                c = char_t'(z85_chars[$urandom_range(RADIX - 1)]);
            end
            push_item(w, c, sos);
        end
        if (hold)
        begin
            @(posedge clk);
            hold_request = 1'b1;
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // encode with reset settings
        push_item(32'h0000_0000, 8'h00, 1'b1);
        push_item(32'hFFFF_FFFF, 8'hFF, 1'b0);
        push_item(32'h8000_0000, 8'h5A, 1'b0);
        push_item(32'h0000_0001, 8'hA5, 1'b0);
        wait_drain();
        write_reg(REG_ROTATION_STEP, 7'd84);
        push_item(32'h1234_5678, 8'h00, 1'b1);
        push_item(32'hFFFF_FFFF, 8'hFF, 1'b0);
        wait_drain();
        // step above the radix
        write_reg(REG_ROTATION_STEP, 7'd127);
        push_item(32'hA5A5_5A5A, 8'h33, 1'b1);
        wait_drain();

        // decode: all-top digits wrap past 32 bits
        write_reg(REG_DIRECTION, 7'(DIR_DECODE));
        write_reg(REG_ROTATION_STEP, 7'd0);
        push_item($urandom, "#", 1'b1);
        repeat (4) push_item($urandom, "#", 1'b0);
        wait_drain();
        write_reg(REG_ROTATION_STEP, 7'd127);
        // unknown bytes, restart mid-group, partial group left open
        push_item($urandom, 8'h00, 1'b1);
        push_item($urandom, "z", 1'b0);
        push_item($urandom, "0", 1'b0);
        push_item($urandom, "Z", 1'b0);
        push_item($urandom, "#", 1'b0);
        push_item($urandom, "1", 1'b0);
        push_item($urandom, ".", 1'b1);
        push_item($urandom, 8'hFF, 1'b0);
        push_item($urandom, "}", 1'b0);
        push_item($urandom, "@", 1'b0);
        push_item($urandom, "%", 1'b0);
        push_item($urandom, "7", 1'b0);
        push_item($urandom, "Q", 1'b0);
        wait_drain();

        run_phase(DIR_ENCODE, 7'd3, 0, 0, 1'b1);
        run_phase(DIR_DECODE, 7'd84, 59, 0, 1'b0);
        run_phase(DIR_ENCODE, 7'd85, 0, 59, 1'b0);
        run_phase(DIR_DECODE, 7'd127, 30, 30, 1'b0);
        run_phase(DIR_ENCODE, 7'($urandom_range(127)), 59, 0, 1'b0);
        run_phase(DIR_DECODE, 7'($urandom_range(127)), 0, 59, 1'b0);
        run_phase(DIR_ENCODE, 7'd1, 30, 30, 1'b0);
        run_phase(DIR_DECODE, 7'd0, 0, 0, 1'b0);

        if (result_q.size() != 0)
        begin
            report_mismatch("results never produced", 40'(result_q.size()), '0);
        end
        $display("tb: %0d items sent, %0d results checked, %0d errors", items_taken,
                 results_checked, errors);
        $display("tb: %0d words encoded, %0d groups decoded, %0d of them flagged bad",
                 words_encoded, groups_decoded, bad_groups);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
